// ===== hw/rtl/aoh_pkg.sv =====
// ----------------------------------------------------------------------------
// aoh_pkg
// Shared constants, types and a half-float compare helper for the box indexer.
// ----------------------------------------------------------------------------
`default_nettype none
package aoh_pkg;
  localparam int LANES = 4;
  localparam int MAX_BOXES = 65536;
  localparam int IDX_W = $clog2(MAX_BOXES) + 1;
  localparam int HIT_CAP = (MAX_BOXES < 131071) ? MAX_BOXES : 131071;
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  localparam logic [1:0] CFG_MIN_X = 2'd0;
  localparam logic [1:0] CFG_MIN_Y = 2'd1;
  localparam logic [1:0] CFG_MAX_X = 2'd2;
  localparam logic [1:0] CFG_MAX_Y = 2'd3;

  localparam logic KIND_HIT = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [15:0] min_x;
    logic [15:0] min_y;
    logic [15:0] max_x;
    logic [15:0] max_y;
  } query_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] box_index;
    logic [16:0] hit_total;
    logic        overflow;
    logic        last;
  } result_t;

  function automatic logic half_lt(input logic [15:0] a, input logic [15:0] b);
    logic        nan_a;
    logic        nan_b;
    logic [16:0] ka;
    logic [16:0] kb;
    nan_a = (a[14:10] == 5'h1f) && (a[9:0] != 10'd0);
    nan_b = (b[14:10] == 5'h1f) && (b[9:0] != 10'd0);
    ka = a[15] ? (17'd0 - {2'b00, a[14:0]}) : {2'b00, a[14:0]};
    kb = b[15] ? (17'd0 - {2'b00, b[14:0]}) : {2'b00, b[14:0]};
    half_lt = !nan_a && !nan_b && ($signed(ka) < $signed(kb));
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/aoh_lane.sv =====
// ----------------------------------------------------------------------------
// aoh_lane
// One box-versus-query overlap test with IEEE ordered half compares.
// ----------------------------------------------------------------------------
`default_nettype none
module aoh_lane import aoh_pkg::*; (
  input  wire query_t      query,
  input  wire logic [15:0] bmin_x,
  input  wire logic [15:0] bmin_y,
  input  wire logic [15:0] bmax_x,
  input  wire logic [15:0] bmax_y,
  output logic             hit
);
  assign hit = half_lt(query.min_x, bmax_x) && half_lt(query.min_y, bmax_y) &&
               half_lt(bmin_x, query.max_x) && half_lt(bmin_y, query.max_y);
endmodule
`default_nettype wire

// ===== hw/rtl/aoh_merge.sv =====
// ----------------------------------------------------------------------------
// aoh_merge
// Holds one item's lane hits and emits hit indices in lane order, then the
// summary on a last item, through a single output register.
// ----------------------------------------------------------------------------
`default_nettype none
module aoh_merge import aoh_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire logic [LANES-1:0] hits,
  input  wire logic             last_item,
  output logic                  busy,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output result_t               out_data
);
  logic [LANES-1:0] pend_r, pend_nxt;
  logic             sum_r, sum_nxt;
  logic [IDX_W-1:0] item_r, item_nxt, base_r, base_nxt;
  logic [16:0]      hcnt_r, hcnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             ov_r, ov_nxt;
  result_t          od_r, od_nxt;

  logic             slot_free;
  logic [LANE_W-1:0] sel;
  logic             any;
  logic [LANES-1:0] rest;
  logic [IDX_W-1:0] idx;
  logic [16:0]      hc;

  always_comb begin
    sel = '0;
    any = 1'b0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (pend_r[l]) begin
        sel = LANE_W'(l);
        any = 1'b1;
      end
    end
  end

  assign slot_free = !ov_r || out_ready;
  assign busy = (pend_r != '0) || sum_r;
  assign out_valid = ov_r;
  assign out_data = od_r;

  always_comb begin
    pend_nxt = pend_r;
    sum_nxt = sum_r;
    item_nxt = item_r;
    base_nxt = base_r;
    hcnt_nxt = hcnt_r;
    ovf_nxt = ovf_r;
    ov_nxt = ov_r && !out_ready;
    od_nxt = od_r;
    rest = pend_r;
    rest[sel] = 1'b0;
    idx = base_r + IDX_W'(sel);
    hc = (hcnt_r < 17'(HIT_CAP)) ? hcnt_r + 17'd1 : hcnt_r;
    if (load) begin
      pend_nxt = hits;
      sum_nxt = last_item;
      base_nxt = item_r * IDX_W'(LANES);
      ovf_nxt = ovf_r || (base_r + IDX_W'(LANES - 1) >= IDX_W'(MAX_BOXES));
      if (item_r * IDX_W'(LANES) < IDX_W'(MAX_BOXES)) begin
        item_nxt = item_r + IDX_W'(1);
      end
    end else if (slot_free && any) begin
      pend_nxt = rest;
      hcnt_nxt = hc;
      ov_nxt = 1'b1;
      od_nxt.kind = KIND_HIT;
      if (idx >= IDX_W'(MAX_BOXES)) begin
        ovf_nxt = 1'b1;
        od_nxt.box_index = 16'(MAX_BOXES - 1);
        od_nxt.overflow = 1'b1;
      end else begin
        od_nxt.box_index = idx[15:0];
        od_nxt.overflow = ovf_r;
      end
      od_nxt.hit_total = hc;
      od_nxt.last = (rest == '0) && !sum_r;
    end else if (slot_free && sum_r) begin
      sum_nxt = 1'b0;
      ov_nxt = 1'b1;
      od_nxt.kind = KIND_SUMMARY;
      od_nxt.box_index = '0;
      od_nxt.hit_total = hcnt_r;
      od_nxt.overflow = ovf_r || (base_r + IDX_W'(LANES - 1) >= IDX_W'(MAX_BOXES));
      od_nxt.last = 1'b1;
      item_nxt = '0;
      base_nxt = '0;
      hcnt_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      sum_r <= 1'b0;
      item_r <= '0;
      base_r <= '0;
      hcnt_r <= '0;
      ovf_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      sum_r <= sum_nxt;
      item_r <= item_nxt;
      base_r <= base_nxt;
      hcnt_r <= hcnt_nxt;
      ovf_r <= ovf_nxt;
      ov_r <= ov_nxt;
    end
    od_r <= od_nxt;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/aabb_overlap_hit_indexer.sv =====
// ----------------------------------------------------------------------------
// aabb_overlap_hit_indexer
// Tests four half-float boxes per transaction against a configured query box.
// ----------------------------------------------------------------------------
// Usage:
//   The cfg channel writes the query box (index 0..3: min x, min y, max x,
//   max y); other indexes are ignored. Write only while the block is idle.
//   Each in transaction carries four boxes, one per 16-bit lane. All four
//   lane comparators run in the cycle of acceptance and the hit vector is
//   registered. The merge stage then emits one result per cycle unless the
//   receiver stalls: hit indices in ascending order, then a summary if
//   last_item was set. Results pass from the pending-hit register to the
//   output register. An item's results leave one at a time through the
//   single result register, which sets the rate. The next item is taken
//   once the previous one's results are all in the output register.
//   A stalled receiver holds out_valid and the result; emission pauses.
//   Reset clears the query box, the counters and any pending results.
// ----------------------------------------------------------------------------
`default_nettype none
module aabb_overlap_hit_indexer import aoh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_box_min_x,
  input  wire logic [63:0] in_box_min_y,
  input  wire logic [63:0] in_box_max_x,
  input  wire logic [63:0] in_box_max_y,
  input  wire logic        in_last_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [15:0]      out_box_index,
  output logic [16:0]      out_hit_total,
  output logic             out_overflow,
  output logic             out_last
);
  query_t           query_r;
  logic [LANES-1:0] hits;
  logic             busy;
  logic             load_r;
  logic             load;
  result_t          res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_X: query_r.min_x <= cfg_data;
        CFG_MIN_Y: query_r.min_y <= cfg_data;
        CFG_MAX_X: query_r.max_x <= cfg_data;
        CFG_MAX_Y: query_r.max_y <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [15:0] a, b, c, d;
    if (l < 4) begin : g_real
      assign a = in_box_min_x[16*l +: 16];
      assign b = in_box_min_y[16*l +: 16];
      assign c = in_box_max_x[16*l +: 16];
      assign d = in_box_max_y[16*l +: 16];
    end else begin : g_zero
      assign a = '0;
      assign b = '0;
      assign c = '0;
      assign d = '0;
    end
    aoh_lane u_lane (
      .query (query_r),
      .bmin_x(a),
      .bmin_y(b),
      .bmax_x(c),
      .bmax_y(d),
      .hit   (hits[l])
    );
  end

  assign in_ready = !busy && !load_r;
  assign load = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= 1'b0;
    end else begin
      load_r <= load;
    end
  end

  aoh_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .hits     (hits),
    .last_item(in_last_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (res)
  );

  assign out_kind = res.kind;
  assign out_box_index = res.box_index;
  assign out_hit_total = res.hit_total;
  assign out_overflow = res.overflow;
  assign out_last = res.last;

`ifndef SYNTHESIS
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !busy) else $error("item accepted while results pending");
  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SUMMARY |-> out_last)
    else $error("summary without last");
  a_hit_total_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_HIT |-> out_hit_total != 17'd0)
    else $error("hit with zero count");
`endif
endmodule
`default_nettype wire
